// ----- sv/lwpsw_pkg.sv -----
// shared types and constants for the lcd window pixel stream writer
// no dependencies; imported by every module of the block
`default_nettype none

package lwpsw_pkg;

    localparam int SIDE_W    = 11;  // panel size register width, bounds every clipped side
    localparam int BURST_MAX = 11;  // longest byte burst, the window command sequence
    localparam int CNT_W     = 4;   // holds 0 .. BURST_MAX

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_18BIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_RB      = 3'd5;

    localparam logic FUNC_WINDOW = 1'b0;
    localparam logic FUNC_PIXEL  = 1'b1;

    localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR  = 8'h2B;
    localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

    // data/command flags of the window sequence, bit 0 goes out first
    localparam logic [BURST_MAX-1:0] WIN_DC_MASK = 11'b01111011110;

    // window after clipping, all coordinates relative to the panel
    typedef struct packed {
        logic              ok;
        logic [SIDE_W-1:0] x;
        logic [SIDE_W-1:0] xe;
        logic [SIDE_W-1:0] y;
        logic [SIDE_W-1:0] ye;
        logic [SIDE_W-1:0] w;
        logic [SIDE_W-1:0] h;
    } t_win;

    // bytes caused by one input item, element 0 goes out first
    typedef struct packed {
        logic [CNT_W-1:0]            n;
        logic [BURST_MAX-1:0]        dc;
        logic                        eot;
        logic [BURST_MAX-1:0][7:0]   bytes;
    } t_burst;

endpackage

`default_nettype wire

// ----- sv/lwpsw_clip.sv -----
// window clip and bounds check, combinational, evaluated on the input item
// depends on lwpsw_pkg
`default_nettype none

module lwpsw_clip import lwpsw_pkg::*; #(
    parameter int MAX_SIDE = 1024
) (
    input  wire logic [11:0]       i_x,
    input  wire logic [11:0]       i_y,
    input  wire logic [11:0]       i_w,
    input  wire logic [11:0]       i_h,
    input  wire logic              i_clip,
    input  wire logic [SIDE_W-1:0] i_panel_width,
    input  wire logic [SIDE_W-1:0] i_panel_height,
    output t_win                   o_win
);

    localparam logic [12:0] SAT = 13'(MAX_SIDE);

    typedef struct packed {
        logic              ok;
        logic [SIDE_W-1:0] start;
        logic [SIDE_W-1:0] stop;
        logic [SIDE_W-1:0] len;
    } t_axis;

    function automatic logic signed [13:0] f_limit(input logic [SIDE_W-1:0] v);
        logic [12:0] e;
        e = {2'b00, v};
        if (e > SAT) begin
            e = SAT;
        end
        return signed'({1'b0, e});
    endfunction

    function automatic t_axis f_axis(input logic signed [13:0] p,
                                     input logic signed [13:0] l,
                                     input logic signed [13:0] lim,
                                     input logic               clip);
        logic signed [13:0] ps;
        logic signed [13:0] ls;
        logic signed [13:0] pe;
        t_axis              r;
        ps   = p;
        ls   = l;
        r.ok = 1'b1;
        if (clip) begin
            if (p < 0) begin
                ls = l + p;
                ps = '0;
            end
            if (ps >= lim) begin
                r.ok = 1'b0;
            end else begin
                if (ps + ls > lim) begin
                    ls = lim - ps;
                end
                if (ls <= 0) begin
                    r.ok = 1'b0;
                end
            end
        end else begin
            if (p < 0 || p + l > lim) begin
                r.ok = 1'b0;
            end
        end
        pe      = ps + ls - 14'sd1;
        r.start = ps[SIDE_W-1:0];
        r.stop  = pe[SIDE_W-1:0];
        r.len   = ls[SIDE_W-1:0];
        return r;
    endfunction

    logic signed [13:0] x_s, y_s, w_s, h_s;
    t_axis              ax, ay;

    assign x_s = 14'(signed'(i_x));
    assign y_s = 14'(signed'(i_y));
    assign w_s = 14'(signed'(i_w));
    assign h_s = 14'(signed'(i_h));

    assign ax = f_axis(x_s, w_s, f_limit(i_panel_width), i_clip);
    assign ay = f_axis(y_s, h_s, f_limit(i_panel_height), i_clip);

    always_comb begin
        o_win.ok = (w_s > 0) && (h_s > 0) && ax.ok && ay.ok;
        o_win.x  = ax.start;
        o_win.xe = ax.stop;
        o_win.w  = ax.len;
        o_win.y  = ay.start;
        o_win.ye = ay.stop;
        o_win.h  = ay.len;
    end

endmodule

`default_nettype wire

// ----- sv/lwpsw_burst_build.sv -----
// builds the byte burst of one item and keeps the pending pixel count
// depends on lwpsw_pkg
`default_nettype none

module lwpsw_burst_build import lwpsw_pkg::*; #(
    parameter int MAX_SIDE = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_adv,
    input  wire logic        i_func,
    input  wire t_win        i_win,
    input  wire logic [15:0] i_color,
    input  wire logic [15:0] i_x_offset,
    input  wire logic [15:0] i_y_offset,
    input  wire logic        i_pixel_18bit,
    input  wire logic        i_swap_red_blue,
    output t_burst           o_burst,
    output logic             o_pend_zero
);

    localparam int SIDE_MAX = (MAX_SIDE < 2047) ? MAX_SIDE : 2047;
    localparam int PEND_W   = $clog2(SIDE_MAX * SIDE_MAX + 1);

    logic [PEND_W-1:0]   r_pending, n_pending;
    logic [2*SIDE_W-1:0] prod;
    logic [15:0]         xs, xe, ys, ye, c;
    logic [4:0]          r5, b5;
    logic [5:0]          g6;

    assign prod = {{SIDE_W{1'b0}}, i_win.w} * {{SIDE_W{1'b0}}, i_win.h};
    assign xs   = i_x_offset + 16'(i_win.x);
    assign xe   = i_x_offset + 16'(i_win.xe);
    assign ys   = i_y_offset + 16'(i_win.y);
    assign ye   = i_y_offset + 16'(i_win.ye);

    assign c  = i_swap_red_blue ? {i_color[4:0], i_color[10:5], i_color[15:11]} : i_color;
    assign r5 = c[15:11];
    assign g6 = c[10:5];
    assign b5 = c[4:0];

    assign o_pend_zero = (r_pending == '0);

    always_comb begin
        n_pending     = r_pending;
        o_burst.n     = '0;
        o_burst.dc    = '0;
        o_burst.eot   = 1'b0;
        o_burst.bytes = '0;
        case (i_func)
            FUNC_WINDOW: begin
                if (i_win.ok) begin
                    n_pending         = prod[PEND_W-1:0];
                    o_burst.n         = CNT_W'(BURST_MAX);
                    o_burst.dc        = WIN_DC_MASK;
                    o_burst.bytes[0]  = CMD_COL_ADDR;
                    o_burst.bytes[1]  = xs[15:8];
                    o_burst.bytes[2]  = xs[7:0];
                    o_burst.bytes[3]  = xe[15:8];
                    o_burst.bytes[4]  = xe[7:0];
                    o_burst.bytes[5]  = CMD_ROW_ADDR;
                    o_burst.bytes[6]  = ys[15:8];
                    o_burst.bytes[7]  = ys[7:0];
                    o_burst.bytes[8]  = ye[15:8];
                    o_burst.bytes[9]  = ye[7:0];
                    o_burst.bytes[10] = CMD_MEM_WRITE;
                end else begin
                    n_pending = '0;
                end
            end
            FUNC_PIXEL: begin
                if (r_pending != '0) begin
                    n_pending   = r_pending - PEND_W'(1);
                    o_burst.eot = (r_pending == PEND_W'(1));
                    o_burst.dc  = '1;
                    if (i_pixel_18bit) begin
                        o_burst.n        = CNT_W'(3);
                        o_burst.bytes[0] = {r5, r5[4:2]};
                        o_burst.bytes[1] = {g6, g6[5:4]};
                        o_burst.bytes[2] = {b5, b5[4:2]};
                    end else begin
                        o_burst.n        = CNT_W'(2);
                        o_burst.bytes[0] = c[15:8];
                        o_burst.bytes[1] = c[7:0];
                    end
                end
            end
            default: begin
                n_pending = r_pending;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (i_valid && i_adv) begin
            r_pending <= n_pending;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lwpsw_byte_shifter.sv -----
// holds one burst and shifts it out one byte per cycle on the output stream while tready is high
// depends on lwpsw_pkg
`default_nettype none

module lwpsw_byte_shifter import lwpsw_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_load,
    input  wire t_burst     i_burst,
    input  wire logic       i_tready,
    output logic            o_free,
    output logic            o_tvalid,
    output logic [7:0]      o_tdata,
    output logic [1:0]      o_tuser,
    output logic            o_tlast
);

    logic [CNT_W-1:0]          r_left;
    logic [BURST_MAX-1:0][7:0] r_bytes;
    logic [BURST_MAX-1:0]      r_dc;
    logic                      r_eot;
    logic                      take;

    assign o_tvalid = (r_left != '0);
    assign take     = o_tvalid && i_tready;
    assign o_tlast  = (r_left == CNT_W'(1));
    assign o_free   = (r_left == '0) || (o_tlast && i_tready);
    assign o_tdata  = r_bytes[0];
    assign o_tuser  = {r_eot && o_tlast, r_dc[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_load) begin
            r_left <= i_burst.n;
        end else if (take) begin
            r_left <= r_left - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_burst.bytes;
            r_dc    <= i_burst.dc;
            r_eot   <= i_burst.eot;
        end else if (take) begin
            r_bytes <= r_bytes >> 8;
            r_dc    <= r_dc >> 1;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lcd_window_pixel_stream_writer.sv -----
// an accepted item passes the input register, then the byte shifter, which shows its first byte
// one output byte per cycle while the output is ready; a pixel item gives 3 bytes (RGB888) or 2 (RGB565),
// a window item 11, a rejected window or an idle pixel none; set by the single byte output register
// synchronous active-low reset clears the pending count, stages and config to defaults
// depends on lwpsw_pkg, lwpsw_clip, lwpsw_burst_build, lwpsw_byte_shifter
`default_nettype none

module lcd_window_pixel_stream_writer import lwpsw_pkg::*; #(
    parameter int MAX_SIDE = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [71:0]          i_s_axis_tdata,  // x, y, w, h, clip, color, zero fill
    input  wire logic [0:0]           i_s_axis_tuser,  // func
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [7:0]                o_m_axis_tdata,  // out_byte
    output logic [1:0]                o_m_axis_tuser,  // is_data, end_of_transfer
    output logic                      o_m_axis_tlast,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    logic [15:0]       r_x_offset, r_y_offset;
    logic [SIDE_W-1:0] r_panel_width, r_panel_height;
    logic              r_pixel_18bit, r_swap_red_blue;

    logic              r_in_valid;
    logic              r_func;
    t_win              r_win;
    logic [15:0]       r_color;

    t_win              w_win;
    t_burst            w_burst;
    logic              w_free, w_pend_zero, w_load, in_take;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_in_valid || w_free;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load          = r_in_valid && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset      <= '0;
            r_y_offset      <= '0;
            r_panel_width   <= 11'd480;
            r_panel_height  <= 11'd320;
            r_pixel_18bit   <= 1'b1;
            r_swap_red_blue <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_X_OFFSET:     r_x_offset      <= i_cfg_data;
                CFG_Y_OFFSET:     r_y_offset      <= i_cfg_data;
                CFG_PANEL_WIDTH:  r_panel_width   <= i_cfg_data[SIDE_W-1:0];
                CFG_PANEL_HEIGHT: r_panel_height  <= i_cfg_data[SIDE_W-1:0];
                CFG_PIXEL_18BIT:  r_pixel_18bit   <= i_cfg_data[0];
                CFG_SWAP_RB:      r_swap_red_blue <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    lwpsw_clip #(.MAX_SIDE(MAX_SIDE)) u_clip (
        .i_x            (i_s_axis_tdata[11:0]),
        .i_y            (i_s_axis_tdata[23:12]),
        .i_w            (i_s_axis_tdata[35:24]),
        .i_h            (i_s_axis_tdata[47:36]),
        .i_clip         (i_s_axis_tdata[48]),
        .i_panel_width  (r_panel_width),
        .i_panel_height (r_panel_height),
        .o_win          (w_win)
    );

    // input register: clipped window or raw colour
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_func  <= i_s_axis_tuser[0];
            r_win   <= w_win;
            r_color <= i_s_axis_tdata[64:49];
        end
    end

    lwpsw_burst_build #(.MAX_SIDE(MAX_SIDE)) u_build (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_in_valid),
        .i_adv           (w_free),
        .i_func          (r_func),
        .i_win           (r_win),
        .i_color         (r_color),
        .i_x_offset      (r_x_offset),
        .i_y_offset      (r_y_offset),
        .i_pixel_18bit   (r_pixel_18bit),
        .i_swap_red_blue (r_swap_red_blue),
        .o_burst         (w_burst),
        .o_pend_zero     (w_pend_zero)
    );

    lwpsw_byte_shifter u_shift (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_burst  (w_burst),
        .i_tready (i_m_axis_tready),
        .o_free   (w_free),
        .o_tvalid (o_m_axis_tvalid),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser),
        .o_tlast  (o_m_axis_tlast)
    );

    // a loaded burst with bytes must show up on the output next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_burst.n != '0) |=> o_m_axis_tvalid)
        else $error("loaded burst not presented");

    // a pixel with nothing pending gives no bytes
    a_pix_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_func == FUNC_PIXEL && w_pend_zero) |-> (w_burst.n == '0))
        else $error("pixel emitted with no pending count");

    // a rejected window clears the pending count
    a_reject_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_func == FUNC_WINDOW && !r_win.ok) |=> w_pend_zero)
        else $error("rejected window left pixels pending");

endmodule

`default_nettype wire
